>>> src/drla_pkg.sv
// ----------------------------------------------------------------------------
// drla_pkg
// shared widths, register indexes, region codes, controller states and the
// command and status structs of the diamond region luma averager
// ----------------------------------------------------------------------------
package drla_pkg;

    localparam int MAX_DIM  = 1024;
    localparam int REGIONS  = 4;

    localparam int CNT_W    = $clog2(MAX_DIM);
    localparam int DIM_W    = 11;
    localparam int LEVEL_W  = 8;
    localparam int WEIGHT_W = 16;
    localparam int PROD_W   = LEVEL_W + WEIGHT_W;
    localparam int LUMA_W   = 26;
    localparam int SUM_W    = 46;
    localparam int PIX_W    = 20;
    localparam int AVG_W    = 26;
    localparam int RGN_W    = $clog2(REGIONS);
    localparam int STEP_W   = $clog2(AVG_W);
    localparam int IDX_W    = 4;
    localparam int CFG_W    = 16;

    localparam logic [IDX_W-1:0] REG_IMAGE_DIM    = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_RED_WEIGHT   = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_GREEN_WEIGHT = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_BLUE_WEIGHT  = IDX_W'(3);

    localparam logic [DIM_W-1:0]    RST_IMAGE_DIM    = DIM_W'(64);
    localparam logic [WEIGHT_W-1:0] RST_RED_WEIGHT   = WEIGHT_W'(19595);
    localparam logic [WEIGHT_W-1:0] RST_GREEN_WEIGHT = WEIGHT_W'(38470);
    localparam logic [WEIGHT_W-1:0] RST_BLUE_WEIGHT  = WEIGHT_W'(7471);

    localparam logic [RGN_W-1:0] RGN_LEFT   = RGN_W'(0);
    localparam logic [RGN_W-1:0] RGN_TOP    = RGN_W'(1);
    localparam logic [RGN_W-1:0] RGN_RIGHT  = RGN_W'(2);
    localparam logic [RGN_W-1:0] RGN_BOTTOM = RGN_W'(3);

    typedef enum logic [2:0] {
        S_RUN,
        S_DRAIN,
        S_DIV_LOAD,
        S_DIV_STEP,
        S_DIV_STORE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic pix_take;
        logic div_load;
        logic div_step;
        logic div_store;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last_pixel;
        logic out_free;
    } t_status;

endpackage

>>> src/drla_ctrl.sv
// ----------------------------------------------------------------------------
// drla_ctrl
// frame sequencer: pixel intake, pipeline drain, per-region division
// steps and result hand-off
// ----------------------------------------------------------------------------
module drla_ctrl
    import drla_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_pix_valid,
    output logic    o_pix_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(AVG_W - 1);
    localparam logic [STEP_W-1:0] LAST_DRAIN = STEP_W'(1);
    localparam logic [RGN_W-1:0]  LAST_RGN   = RGN_W'(REGIONS - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [RGN_W-1:0]  r_region, n_region;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_RUN;
            r_step   <= '0;
            r_region <= '0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_region <= n_region;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_region = r_region;
        case (r_state)
            S_RUN: begin
                n_step = '0;
                if (i_pix_valid && i_status.last_pixel) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_step == LAST_DRAIN) begin
                    n_step  = '0;
                    n_state = S_DIV_LOAD;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_DIV_LOAD: begin
                n_step  = '0;
                n_state = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                if (r_step == LAST_STEP) begin
                    n_state = S_DIV_STORE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_DIV_STORE: begin
                if (r_region == LAST_RGN) begin
                    n_region = '0;
                    n_state  = S_OUT;
                end else begin
                    n_region = r_region + RGN_W'(1);
                    n_state  = S_DIV_LOAD;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_pix_ready = 1'b0;
        case (r_state)
            S_RUN: begin
                o_pix_ready    = 1'b1;
                o_cmd.pix_take = i_pix_valid;
            end
            S_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
            end
            S_DIV_STEP: begin
                o_cmd.div_step = 1'b1;
            end
            S_DIV_STORE: begin
                o_cmd.div_store = 1'b1;
            end
            S_OUT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> src/drla_datapath.sv
// ----------------------------------------------------------------------------
// drla_datapath
// configuration registers, raster counters and region sort, luma pipeline,
// region accumulators, shared restoring divider and result registers
// ----------------------------------------------------------------------------
module drla_datapath
    import drla_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic [LEVEL_W-1:0]  i_red_level,
    input  logic [LEVEL_W-1:0]  i_green_level,
    input  logic [LEVEL_W-1:0]  i_blue_level,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic [AVG_W-1:0]    o_left_average,
    output logic [AVG_W-1:0]    o_top_average,
    output logic [AVG_W-1:0]    o_right_average,
    output logic [AVG_W-1:0]    o_bottom_average,
    output logic [AVG_W-1:0]    o_brightest_average,
    output logic [REGIONS-1:0]  o_empty_regions
);

    localparam logic [DIM_W-1:0] MIN_SIDE = DIM_W'(4);
    localparam logic [DIM_W-1:0] MAX_SIDE = DIM_W'(MAX_DIM);

    logic [DIM_W-1:0]    r_image_dim;
    logic [WEIGHT_W-1:0] r_red_w, r_green_w, r_blue_w;

    logic [CNT_W-1:0]    r_col, r_row;
    logic                r_v1, r_v2;
    logic [RGN_W-1:0]    r_rgn1, r_rgn2;
    logic [PROD_W-1:0]   r_prod_r, r_prod_g, r_prod_b;
    logic [LUMA_W-1:0]   r_luma;
    logic [SUM_W-1:0]    r_sum [REGIONS];
    logic [PIX_W-1:0]    r_pix [REGIONS];

    logic [PIX_W-1:0]    r_rem;
    logic [AVG_W-1:0]    r_quo;
    logic [AVG_W-1:0]    r_avg [REGIONS];
    logic [AVG_W-1:0]    r_best;
    logic [REGIONS-1:0]  r_empty;
    logic                r_res_valid;

    logic [DIM_W-1:0]    w_even, w_dim, w_last, w_half, w_col, w_row, w_k, w_bound;
    logic                w_upper, w_cfg_dim;
    logic [RGN_W-1:0]    w_rgn;
    logic [SUM_W-1:0]    w_dividend;
    logic [PIX_W:0]      w_trial;
    logic                w_fits;
    logic [AVG_W-1:0]    w_avg;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_dim   = i_cfg_valid && (i_cfg_index == REG_IMAGE_DIM);

    // side length, even and saturated
    always_comb begin
        w_even = {r_image_dim[DIM_W-1:1], 1'b0};
        if (w_even < MIN_SIDE) begin
            w_dim = MIN_SIDE;
        end else if (w_even > MAX_SIDE) begin
            w_dim = MAX_SIDE;
        end else begin
            w_dim = w_even;
        end
    end

    // diamond split of the current pixel
    always_comb begin
        w_last  = w_dim - DIM_W'(1);
        w_half  = w_dim >> 1;
        w_col   = DIM_W'(r_col);
        w_row   = DIM_W'(r_row);
        w_upper = w_row < w_half;
        w_k     = w_upper ? w_row : (w_last - w_row);
        w_bound = w_last - w_k;
        if (w_col < w_k) begin
            w_rgn = RGN_LEFT;
        end else if (w_col > w_bound) begin
            w_rgn = RGN_RIGHT;
        end else if (w_upper) begin
            w_rgn = RGN_TOP;
        end else begin
            w_rgn = RGN_BOTTOM;
        end
    end

    assign o_status.last_pixel = (w_col == w_last) && (w_row == w_last);
    assign o_status.out_free   = !r_res_valid || i_res_ready;

    // division of region 0, rounded half up
    assign w_dividend = r_sum[0] + SUM_W'(r_pix[0] >> 1);
    assign w_trial    = {r_rem, r_quo[AVG_W-1]};
    assign w_fits     = w_trial >= {1'b0, r_pix[0]};
    assign w_avg      = (r_pix[0] == '0) ? '0 : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_dim <= RST_IMAGE_DIM;
            r_red_w     <= RST_RED_WEIGHT;
            r_green_w   <= RST_GREEN_WEIGHT;
            r_blue_w    <= RST_BLUE_WEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_DIM:    r_image_dim <= i_cfg_data[DIM_W-1:0];
                REG_RED_WEIGHT:   r_red_w     <= i_cfg_data[WEIGHT_W-1:0];
                REG_GREEN_WEIGHT: r_green_w   <= i_cfg_data[WEIGHT_W-1:0];
                REG_BLUE_WEIGHT:  r_blue_w    <= i_cfg_data[WEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_dim) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.pix_take) begin
            if (w_col == w_last) begin
                r_col <= '0;
                if (w_row == w_last) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + CNT_W'(1);
                end
            end else begin
                r_col <= r_col + CNT_W'(1);
            end
        end
    end

    // luma pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.pix_take;
            r_v2 <= r_v1;
        end
        r_rgn1   <= w_rgn;
        r_prod_r <= PROD_W'(i_red_level) * PROD_W'(r_red_w);
        r_prod_g <= PROD_W'(i_green_level) * PROD_W'(r_green_w);
        r_prod_b <= PROD_W'(i_blue_level) * PROD_W'(r_blue_w);
        r_rgn2   <= r_rgn1;
        r_luma   <= LUMA_W'(r_prod_r) + LUMA_W'(r_prod_g) + LUMA_W'(r_prod_b);
    end

    // region accumulators, rotated down one region per division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_dim) begin
            for (int i = 0; i < REGIONS; i++) begin
                r_sum[i] <= '0;
                r_pix[i] <= '0;
            end
        end else if (i_cmd.div_store) begin
            for (int i = 0; i < REGIONS - 1; i++) begin
                r_sum[i] <= r_sum[i+1];
                r_pix[i] <= r_pix[i+1];
            end
            r_sum[REGIONS-1] <= '0;
            r_pix[REGIONS-1] <= '0;
        end else if (r_v2) begin
            for (int i = 0; i < REGIONS; i++) begin
                if (r_rgn2 == RGN_W'(i)) begin
                    r_sum[i] <= r_sum[i] + SUM_W'(r_luma);
                    r_pix[i] <= r_pix[i] + PIX_W'(1);
                end
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem <= w_dividend[SUM_W-1 -: PIX_W];
            r_quo <= w_dividend[AVG_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= w_fits ? PIX_W'(w_trial - {1'b0, r_pix[0]}) : w_trial[PIX_W-1:0];
            r_quo <= {r_quo[AVG_W-2:0], w_fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else if (i_cmd.out_load) begin
            r_best <= '0;
        end else if (i_cmd.div_store && (w_avg > r_best)) begin
            r_best <= w_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            for (int i = 0; i < REGIONS - 1; i++) begin
                r_avg[i] <= r_avg[i+1];
            end
            r_avg[REGIONS-1] <= w_avg;
            r_empty          <= {(r_pix[0] == '0), r_empty[REGIONS-1:1]};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_left_average      <= r_avg[RGN_LEFT];
            o_top_average       <= r_avg[RGN_TOP];
            o_right_average     <= r_avg[RGN_RIGHT];
            o_bottom_average    <= r_avg[RGN_BOTTOM];
            o_brightest_average <= r_best;
            o_empty_regions     <= r_empty;
        end
    end

    assign o_res_valid = r_res_valid;

endmodule

>>> src/diamond_region_luma_average.sv
// ----------------------------------------------------------------------------
// diamond_region_luma_average
// per-frame mean weighted luma of the four triangles of a diamond split
//
//   channel   direction  handshake                    payload
//   pixel     in         i_pix_valid / o_pix_ready    i_red/green/blue_level
//   result    out        o_res_valid / i_res_ready    four averages, brightest, empty
//   config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// one pixel request per cycle within a frame
// after the last pixel: pipeline drain, then four divisions, one per region, in
// the shared one-bit-per-cycle divider, then the result register is loaded
// the next frame is taken while the result waits, unless an older result
// still blocks the result register
// reset is synchronous, no clearing pass
// ----------------------------------------------------------------------------
module diamond_region_luma_average
    import drla_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_pix_valid,
    output logic                o_pix_ready,
    input  logic [LEVEL_W-1:0]  i_red_level,
    input  logic [LEVEL_W-1:0]  i_green_level,
    input  logic [LEVEL_W-1:0]  i_blue_level,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic [AVG_W-1:0]    o_left_average,
    output logic [AVG_W-1:0]    o_top_average,
    output logic [AVG_W-1:0]    o_right_average,
    output logic [AVG_W-1:0]    o_bottom_average,
    output logic [AVG_W-1:0]    o_brightest_average,
    output logic [REGIONS-1:0]  o_empty_regions,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    drla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .o_pix_ready (o_pix_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    drla_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_red_level         (i_red_level),
        .i_green_level       (i_green_level),
        .i_blue_level        (i_blue_level),
        .o_res_valid         (o_res_valid),
        .i_res_ready         (i_res_ready),
        .o_left_average      (o_left_average),
        .o_top_average       (o_top_average),
        .o_right_average     (o_right_average),
        .o_bottom_average    (o_bottom_average),
        .o_brightest_average (o_brightest_average),
        .o_empty_regions     (o_empty_regions)
    );

endmodule
